// File: rtl/positional_list_store_unit_assert.svh
// Assertion macros used by the list store top module.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// Clocked check, masked while reset is held.
`define PLS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pls_pkg.sv
package pls_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ   = 2'd0,
        OP_LOCATE = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_FIND
    } fsm_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;  // insert commits this cycle
        logic del;  // delete commits this cycle
    } cell_ctl_t;

endpackage

// File: rtl/positional_list_store_unit.sv
// Ordered list of up to DEPTH signed entries, kept packed from position 0, held in a
// row of cells with one entry each. A request (opcode in s_tuser) is accepted in the
// IDLE state, then passes the EXEC state, in which every cell compares and shifts at
// once, and the FIND state, in which the match vector of a locate is resolved to its
// lowest position by the priority encoder; the result then sits in the output register.
// A new request is taken only in IDLE, once the last one has left FIND; a result waiting
// in the output register does not block the next one, but a second finished result waits.
// Every result carries the count after the request; status is in m_tuser.
`include "positional_list_store_unit_assert.svh"

module positional_list_store_unit #(
    parameter int DEPTH      = pls_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = pls_pkg::ELEM_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // position[6:0], item_value[22:7], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[15:0], found_position[21:16],
                                   // entry_count[28:22], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import pls_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    fsm_t state_reg, state_next;

    op_t                   op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [ELEM_WIDTH-1:0] key_reg;
    logic [CW-1:0]         count_reg, count_next;
    status_t               status_reg, status_next;
    logic [ELEM_WIDTH-1:0] rd_reg;
    logic [DEPTH-1:0]      match_reg;

    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    logic                  accept;
    logic                  exec;
    logic                  result_load;

    logic [VAL_W-1:0]      in_value;
    logic [ELEM_WIDTH+VAL_W-1:0] in_ext;
    logic [CMPW-1:0]       pos_c;
    logic [CMPW-1:0]       count_c;
    logic                  full;
    logic                  rd_ok;
    logic                  ins_ok;
    logic                  del_ok;
    cell_ctl_t             ctl;

    logic [ELEM_WIDTH-1:0] cell_value [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_sel   [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic [ELEM_WIDTH-1:0] rd_or;

    logic [IW-1:0]         found_idx;
    logic                  found_any;

    status_t               res_status;
    logic [IW+FPOS_W-1:0]  res_fpos_x;
    logic [ELEM_WIDTH+VAL_W-1:0] res_rd_x;
    logic [CW+COUNT_W-1:0] res_cnt_x;

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (s_tvalid) state_next = FSM_EXEC;
            FSM_EXEC: state_next = FSM_FIND;
            FSM_FIND: if (!m_tvalid_reg || m_tready) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        exec        = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            FSM_IDLE: s_tready = 1'b1;
            FSM_EXEC: exec = 1'b1;
            FSM_FIND: result_load = !m_tvalid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Sign-extend the 16-bit value, then keep the element width.
    assign in_value = s_tdata[22:7];
    assign in_ext   = {{ELEM_WIDTH{in_value[VAL_W-1]}}, in_value};

    assign pos_c   = CMPW'(pos_reg);
    assign count_c = CMPW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign rd_ok   = (pos_c < count_c);
    assign ins_ok  = !full && (pos_c <= count_c);
    assign del_ok  = (pos_c < count_c);

    assign ctl.ins = exec && (op_reg == OP_INSERT) && ins_ok;
    assign ctl.del = exec && (op_reg == OP_DELETE) && del_ok;

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (exec) begin
            case (op_reg)
                OP_READ:   status_next = rd_ok ? ST_OK : ST_MISS;
                OP_LOCATE: status_next = ST_MISS;
                OP_INSERT: status_next = full ? ST_FULL : (ins_ok ? ST_OK : ST_MISS);
                OP_DELETE: status_next = del_ok ? ST_OK : ST_MISS;
                default:   status_next = ST_MISS;
            endcase
            if (ctl.ins) begin
                count_next = count_reg + 1'b1;
            end else if (ctl.del) begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tuser);
            pos_reg <= s_tdata[POS_W-1:0];
            key_reg <= in_ext[ELEM_WIDTH-1:0];
        end
        if (exec) begin
            status_reg <= status_next;
            rd_reg     <= (op_reg == OP_READ && rd_ok) ? rd_or : '0;
            match_reg  <= cell_match;
        end
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] left_v;
        logic [ELEM_WIDTH-1:0] right_v;

        if (g == 0) begin : g_first
            assign left_v = key_reg;
        end else begin : g_mid_l
            assign left_v = cell_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_v = cell_value[g];
        end else begin : g_mid_r
            assign right_v = cell_value[g+1];
        end

        pls_cell #(
            .INDEX      (g),
            .ELEM_WIDTH (ELEM_WIDTH),
            .CW         (CW)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .pos         (pos_reg),
            .count       (count_reg),
            .key         (key_reg),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .match       (cell_match[g]),
            .sel_value   (cell_sel[g])
        );
    end

    // Only the cell at the position drives a nonzero value.
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_sel[i];
        end
    end

    pls_find #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_find (
        .match (match_reg),
        .index (found_idx),
        .any   (found_any)
    );

    // ---------------- result ----------------
    always_comb begin
        res_status = status_reg;
        res_fpos_x = '0;
        if (op_reg == OP_LOCATE) begin
            res_status = found_any ? ST_OK : ST_MISS;
            res_fpos_x = found_any ? {{FPOS_W{1'b0}}, found_idx} : '0;
        end
    end

    assign res_rd_x  = {{VAL_W{1'b0}}, rd_reg};
    assign res_cnt_x = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {3'b000, res_cnt_x[COUNT_W-1:0], res_fpos_x[FPOS_W-1:0],
                            res_rd_x[VAL_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
    `PLS_ASSERT(a_count_bound, aclk, aresetn, (count_reg <= CW'(DEPTH)),
        "entry count above capacity")
    `PLS_ASSERT(a_ins_count, aclk, aresetn, ctl.ins |=> (count_reg == $past(count_reg) + 1'b1),
        "insert did not add one entry")
    `PLS_ASSERT(a_del_count, aclk, aresetn, ctl.del |=> (count_reg == $past(count_reg) - 1'b1),
        "delete did not remove one entry")
    `PLS_ASSERT(a_full_status, aclk, aresetn,
        (exec && status_next == ST_FULL) |-> (count_reg == CW'(DEPTH)),
        "full reported below capacity")
    `PLS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == FSM_IDLE && !m_tvalid_reg),
        "reset left block busy")

endmodule

// File: rtl/pls_cell.sv
module pls_cell #(
    parameter int INDEX      = 0,
    parameter int ELEM_WIDTH = pls_pkg::ELEM_WIDTH_DEF,
    parameter int CW         = 7
) (
    input  logic                    aclk,
    input  pls_pkg::cell_ctl_t      ctl,
    input  logic [pls_pkg::POS_W-1:0] pos,
    input  logic [CW-1:0]           count,
    input  logic [ELEM_WIDTH-1:0]   key,
    input  logic [ELEM_WIDTH-1:0]   left_value,
    input  logic [ELEM_WIDTH-1:0]   right_value,
    output logic [ELEM_WIDTH-1:0]   value,
    output logic                    match,
    output logic [ELEM_WIDTH-1:0]   sel_value
);
    import pls_pkg::*;

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [ELEM_WIDTH-1:0] value_reg;
    logic [ELEM_WIDTH-1:0] value_next;
    logic at_pos;
    logic above_pos;
    logic below_count;

    assign at_pos      = (IDX == 32'(pos));
    assign above_pos   = (IDX > 32'(pos));
    assign below_count = (IDX < 32'(count));

    always_comb begin
        value_next = value_reg;
        if (ctl.ins) begin
            if (above_pos) begin
                value_next = left_value;
            end else if (at_pos) begin
                value_next = key;
            end
        end else if (ctl.del) begin
            if (above_pos || at_pos) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign match     = below_count && (value_reg == key);
    assign sel_value = at_pos ? value_reg : '0;

endmodule

// File: rtl/pls_find.sv
module pls_find #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF,
    parameter int IW    = 6
) (
    input  logic [DEPTH-1:0] match,
    output logic [IW-1:0]    index,
    output logic             any
);
    import pls_pkg::*;

    logic [DEPTH-1:0] lowest;

    // Isolate the lowest set bit, then encode the one-hot word.
    assign lowest = match & (~match + 1'b1);
    assign any    = |match;

    always_comb begin
        index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            for (int b = 0; b < IW; b++) begin
                if (i[b]) begin
                    index[b] = index[b] | lowest[i];
                end
            end
        end
    end

endmodule

// File: bench/positional_list_store_unit_tb.sv
module positional_list_store_unit_tb;
    import pls_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_REQS  = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam int PHASE_GROW   = 0;
    localparam int PHASE_SHRINK = 1;
    localparam int PHASE_MIXED  = 2;

    typedef struct {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } list_req_t;

    typedef struct {
        status_t              status;
        logic [VAL_W-1:0]     read_value;
        logic [FPOS_W-1:0]    found_pos;
        logic [COUNT_W-1:0]   count;
    } list_resp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // position[6:0], item_value[22:7], zero pad
    logic [1:0]  s_tuser  = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // read_value[15:0], found_position[21:16],
                                  // entry_count[28:22], zero pad
    logic [1:0]  m_tuser;         // status[1:0]

    list_req_t        pending_reqs[$];
    list_resp_t       expected_resps[$];
    list_req_t        req_on_bus;
    logic [VAL_W-1:0] shadow_list[LIST_DEPTH];
    int               shadow_count = 0;
    int               send_gap     = 0;
    int               recv_stall   = 0;
    int               cycle_cnt    = 0;
    bit               no_idle      = 1'b0;
    bit               failed       = 1'b0;

    logic [VAL_W-1:0] common_vals[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                         16'h0001, 16'h1234, 16'h5555, 16'haaaa};

    positional_list_store_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one request to the shadow list and returns the response it yields.
    function automatic list_resp_t list_apply(list_req_t r);
        list_resp_t res;
        bit         hit;
        res.status     = ST_MISS;
        res.read_value = '0;
        res.found_pos  = '0;
        hit            = 1'b0;
        case (r.op)
            OP_READ: begin
                if (r.pos < shadow_count) begin
                    res.read_value = shadow_list[r.pos];
                    res.status     = ST_OK;
                end
            end
            OP_LOCATE: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (!hit && shadow_list[i] == r.val) begin
                        hit           = 1'b1;
                        res.found_pos = FPOS_W'(i);
                        res.status    = ST_OK;
                    end
                end
            end
            OP_INSERT: begin
                // full is reported before the position is looked at
                if (shadow_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (r.pos <= shadow_count) begin
                    for (int i = shadow_count; i > int'(r.pos); i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[r.pos] = r.val;
                    shadow_count++;
                    res.status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (r.pos < shadow_count) begin
                    for (int i = int'(r.pos); i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    res.status = ST_OK;
                end
            end
        endcase
        res.count = COUNT_W'(shadow_count);
        return res;
    endfunction

    task automatic queue_req(op_t op, int pos, logic [VAL_W-1:0] val);
        list_req_t r;
        r.op  = op;
        r.pos = POS_W'(pos);
        r.val = val;
        pending_reqs.push_back(r);
    endtask

    // Request driver: prediction happens when the transaction is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_resps.push_back(list_apply(req_on_bus));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tdata  <= {1'b0, req_on_bus.val, req_on_bus.pos};
                    s_tuser  <= req_on_bus.op;
                    s_tvalid <= 1'b1;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random back-pressure.
    always @(posedge aclk) begin : resp_monitor
        int         stall;
        list_resp_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_resps.size() == 0) begin
                    $error("unexpected result transaction: tdata=%h tuser=%h", m_tdata, m_tuser);
                    failed = 1'b1;
                end else begin
                    want = expected_resps.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        failed = 1'b1;
                    end
                    if (m_tdata[15:0] !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(m_tdata[15:0]));
                        failed = 1'b1;
                    end
                    if (m_tdata[21:16] !== want.found_pos) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_pos, m_tdata[21:16]);
                        failed = 1'b1;
                    end
                    if (m_tdata[28:22] !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, m_tdata[28:22]);
                        failed = 1'b1;
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 7);
                recv_stall <= stall;
                m_tready   <= (stall == 0);
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= (recv_stall == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        list_req_t r;
        int        n;
        int        phase_len;
        int        phase_kind;
        int        pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list
        queue_req(OP_READ,   0,   16'h0000);
        queue_req(OP_DELETE, 0,   16'h0000);
        queue_req(OP_LOCATE, 0,   16'h0000);
        queue_req(OP_INSERT, 1,   16'h0005);
        // build [0x1234, min, max, max]: front, middle and end inserts
        queue_req(OP_INSERT, 0,   16'h8000);
        queue_req(OP_INSERT, 1,   16'h7fff);
        queue_req(OP_INSERT, 0,   16'h1234);
        queue_req(OP_INSERT, 3,   16'h7fff);
        queue_req(OP_INSERT, 127, 16'h0000);
        queue_req(OP_READ,   127, 16'hffff);
        queue_req(OP_READ,   0,   16'h0000);
        queue_req(OP_READ,   3,   16'h0000);
        queue_req(OP_READ,   4,   16'h0000);
        // duplicate value: lowest position wins
        queue_req(OP_LOCATE, 127, 16'h7fff);
        queue_req(OP_LOCATE, 0,   16'h8000);
        queue_req(OP_LOCATE, 0,   16'h0000);
        queue_req(OP_DELETE, 4,   16'h0000);
        queue_req(OP_DELETE, 1,   16'h0000);
        queue_req(OP_DELETE, 2,   16'h0000);
        queue_req(OP_LOCATE, 0,   16'h7fff);
        queue_req(OP_DELETE, 0,   16'h0000);
        queue_req(OP_DELETE, 0,   16'h0000);
        queue_req(OP_READ,   0,   16'h0000);
        queue_req(OP_LOCATE, 0,   16'h7fff);

        // Random phases; the first one is a grow phase of 150 requests, weighted to inserts.
        n = 0;
        phase_kind = PHASE_GROW;
        phase_len  = 150;
        while (n < RANDOM_REQS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && n < RANDOM_REQS; k++) begin
                // generate against a shadow list that is at most a few requests stale
                while (pending_reqs.size() >= 2) @(negedge aclk);
                pick = $urandom_range(0, 99);
                case (phase_kind)
                    PHASE_GROW:
                        r.op = pick < 70 ? OP_INSERT : pick < 80 ? OP_DELETE :
                               pick < 90 ? OP_READ : OP_LOCATE;
                    PHASE_SHRINK:
                        r.op = pick < 10 ? OP_INSERT : pick < 70 ? OP_DELETE :
                               pick < 85 ? OP_READ : OP_LOCATE;
                    default:
                        r.op = pick < 30 ? OP_INSERT : pick < 55 ? OP_DELETE :
                               pick < 80 ? OP_READ : OP_LOCATE;
                endcase
                if ($urandom_range(0, 9) == 0 || r.op == OP_LOCATE)
                    r.pos = POS_W'($urandom_range(0, 127));
                else if (r.op == OP_INSERT)
                    r.pos = POS_W'($urandom_range(0, shadow_count));
                else
                    r.pos = shadow_count > 0 ? POS_W'($urandom_range(0, shadow_count - 1)) : '0;
                pick = $urandom_range(0, 99);
                if (r.op == OP_LOCATE && shadow_count > 0 && pick < 60)
                    r.val = shadow_list[$urandom_range(0, shadow_count - 1)];
                else if (pick < 80)
                    r.val = common_vals[$urandom_range(0, 7)];
                else
                    r.val = VAL_W'($urandom_range(0, 16'hffff));
                pending_reqs.push_back(r);
                n++;
            end
            phase_kind = $urandom_range(PHASE_GROW, PHASE_MIXED);
            phase_len  = $urandom_range(40, 140);
        end

        while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (!failed && expected_resps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/pls_find.sv
rtl/positional_list_store_unit.sv
bench/positional_list_store_unit_tb.sv
